// ===== hdl/gubp_pkg.sv =====
// ----------------------------------------------------------------------------
// gubp_pkg
// Shared types and constants for the GNSS UBX/NMEA byte parser.
// ----------------------------------------------------------------------------
package gubp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned OFFSET_W   = 7;
   localparam int unsigned KIND_W     = 2;
   // frame position must reach 7 + 255 after a length change mid-frame
   localparam int unsigned FPOS_W     = 9;
   localparam int unsigned LPOS_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd128;
   localparam logic [LPOS_W-1:0] LINE_MAX    = 8'd128;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;

   // frame positions
   localparam logic [FPOS_W-1:0] POS_CLASS   = 9'd2;
   localparam logic [FPOS_W-1:0] POS_ID      = 9'd3;
   localparam logic [FPOS_W-1:0] POS_LEN_LO  = 9'd4;
   localparam logic [FPOS_W-1:0] POS_LEN_HI  = 9'd5;
   localparam logic [FPOS_W-1:0] POS_PAYLOAD = 9'd6;
   localparam logic [FPOS_W-1:0] POS_IDLE    = 9'd0;

   localparam logic [BYTE_W-1:0] RST_PAYLOAD_LENGTH = 8'd92;
   localparam logic [BYTE_W-1:0] RST_ACCEPT_CLASS   = 8'd1;
   localparam logic [BYTE_W-1:0] RST_ACCEPT_ID      = 8'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAYLOAD_LENGTH = 2'd0,
      CSR_ACCEPT_CLASS   = 2'd1,
      CSR_ACCEPT_ID      = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE    = 2'd0,
      KIND_LINE    = 2'd1,
      KIND_PAYLOAD = 2'd2
   } byte_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_length;
      logic [BYTE_W-1:0] accept_class;
      logic [BYTE_W-1:0] accept_id;
   } csr_type;

   typedef struct packed {
      logic                payload;
      logic [OFFSET_W-1:0] offset;
      logic                frame_done;
      logic                frame_ok;
      logic                length_rejected;
      logic [BYTE_W-1:0]   frame_class;
      logic [BYTE_W-1:0]   frame_msg_id;
   } frame_res_type;

   typedef struct packed {
      logic                stored;
      logic [OFFSET_W-1:0] offset;
      logic                line_done;
      logic [LPOS_W-1:0]   line_length;
   } line_res_type;

endpackage

// ===== hdl/gubp_frame.sv =====
// ----------------------------------------------------------------------------
// gubp_frame
// UBX frame tracker: sync detection, header capture, length check, payload
// offsets and the 8-bit Fletcher checksum.
// ----------------------------------------------------------------------------
module gubp_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [gubp_pkg::BYTE_W-1:0] rx_byte,
   input  gubp_pkg::csr_type         csr,
   output logic                      in_frame,
   output gubp_pkg::frame_res_type   res
);
   import gubp_pkg::*;

   logic              in_frame_ff, in_frame_in;
   logic [FPOS_W-1:0] pos_ff, pos_in;
   logic              sync_ff, sync_in;
   logic [BYTE_W-1:0] class_ff, class_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] len_lo_ff, len_lo_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] check_a_ff, check_a_in;

   logic [BYTE_W-1:0] sum_a_add, sum_b_add;
   logic [FPOS_W-1:0] len_ext, check_a_pos, check_b_pos, pos_inc;
   logic              do_sum;

   assign sum_a_add   = sum_a_ff + rx_byte;
   assign sum_b_add   = sum_b_ff + sum_a_add;
   assign len_ext     = {{(FPOS_W-BYTE_W){1'b0}}, csr.payload_length};
   assign check_a_pos = POS_PAYLOAD + len_ext;
   assign check_b_pos = check_a_pos + 9'd1;
   assign pos_inc     = pos_ff + 9'd1;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      len_lo_in   = len_lo_ff;
      check_a_in  = check_a_ff;
      do_sum      = 1'b0;
      res         = '0;

      if (in_frame_ff) begin
         if (pos_ff == POS_CLASS) begin
            class_in = rx_byte;
            do_sum   = 1'b1;
            pos_in   = POS_ID;
         end else if (pos_ff == POS_ID) begin
            id_in  = rx_byte;
            do_sum = 1'b1;
            pos_in = POS_LEN_LO;
         end else if (pos_ff == POS_LEN_LO) begin
            len_lo_in = rx_byte;
            do_sum    = 1'b1;
            pos_in    = POS_LEN_HI;
         end else if (pos_ff == POS_LEN_HI) begin
            do_sum = 1'b1;
            if (rx_byte != '0 || len_lo_ff != csr.payload_length ||
                csr.payload_length > MAX_PAYLOAD) begin
               in_frame_in         = 1'b0;
               res.length_rejected = 1'b1;
            end
            pos_in = POS_PAYLOAD;
         end else if (pos_ff >= POS_PAYLOAD && pos_ff < check_a_pos) begin
            do_sum      = 1'b1;
            res.payload = 1'b1;
            res.offset  = OFFSET_W'(pos_ff - POS_PAYLOAD);
            pos_in      = pos_inc;
         end else if (pos_ff == check_a_pos) begin
            check_a_in = rx_byte;
            pos_in     = pos_inc;
         end else if (pos_ff == check_b_pos) begin
            res.frame_done = 1'b1;
            res.frame_ok   = (class_ff == csr.accept_class) && (id_ff == csr.accept_id) &&
                             (check_a_ff == sum_a_ff) && (rx_byte == sum_b_ff);
            pos_in      = POS_IDLE;
            in_frame_in = 1'b0;
         end else begin
            in_frame_in = 1'b0;
            pos_in      = POS_IDLE;
         end
      end

      sum_a_in = do_sum ? sum_a_add : sum_a_ff;
      sum_b_in = do_sum ? sum_b_add : sum_b_ff;

      // a completed sync pair restarts the frame, whatever came before
      if (rx_byte == SYNC_SECOND && sync_ff) begin
         in_frame_in = 1'b1;
         pos_in      = POS_CLASS;
         sum_a_in    = '0;
         sum_b_in    = '0;
      end
      sync_in = (rx_byte == SYNC_FIRST);

      res.frame_class  = class_in;
      res.frame_msg_id = id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         sync_ff     <= 1'b0;
         class_ff    <= '0;
         id_ff       <= '0;
         len_lo_ff   <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         check_a_ff  <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         sync_ff     <= sync_in;
         class_ff    <= class_in;
         id_ff       <= id_in;
         len_lo_ff   <= len_lo_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         check_a_ff  <= check_a_in;
      end
   end

   assign in_frame = in_frame_ff;

endmodule

// ===== hdl/gubp_line.sv =====
// ----------------------------------------------------------------------------
// gubp_line
// NMEA text line assembler: character offsets and line length on CR/LF.
// ----------------------------------------------------------------------------
module gubp_line (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        in_frame,
   input  logic [gubp_pkg::BYTE_W-1:0] rx_byte,
   output gubp_pkg::line_res_type      res
);
   import gubp_pkg::*;

   logic [LPOS_W-1:0] pos_ff, pos_in;
   logic [LPOS_W-1:0] base;

   // '$' or a full line starts over at offset zero
   assign base = (rx_byte == CHAR_DOLLAR || pos_ff >= LINE_MAX) ? '0 : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      res    = '0;
      if (!in_frame) begin
         if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
            if (pos_ff != '0) begin
               res.line_done   = 1'b1;
               res.line_length = pos_ff;
               pos_in          = '0;
            end
         end else begin
            res.stored = 1'b1;
            res.offset = base[OFFSET_W-1:0];
            pos_in     = base + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hdl/gnss_ubx_nmea_byte_parser_unit.sv =====
// ----------------------------------------------------------------------------
// gnss_ubx_nmea_byte_parser_unit
// Byte parser for a GNSS receiver stream: UBX frames and NMEA text lines.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and gives one result per byte, at a
// sustained rate of one transfer per cycle while rsp_stall stays low. A
// byte is captured in an input register, parsed in the following cycle
// against the frame and line state, and the result lands in an output
// register that drives rsp_valid. When the result register is stalled,
// the input register holds its byte and req_stall rises; otherwise the two
// sides run independently. Configuration writes are taken in any cycle
// (csr_ready is always high) and should only be issued while the parser is
// idle; indices outside the register list are ignored.
module gnss_ubx_nmea_byte_parser_unit (
   input  logic                           clock,
   input  logic                           reset,
   // byte input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gubp_pkg::BYTE_W-1:0]    req_rx_byte,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gubp_pkg::KIND_W-1:0]    rsp_byte_kind,
   output logic [gubp_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [gubp_pkg::OFFSET_W-1:0]  rsp_byte_offset,
   output logic                           rsp_line_done,
   output logic [gubp_pkg::LPOS_W-1:0]    rsp_line_length,
   output logic                           rsp_frame_done,
   output logic                           rsp_frame_ok,
   output logic [gubp_pkg::BYTE_W-1:0]    rsp_frame_class,
   output logic [gubp_pkg::BYTE_W-1:0]    rsp_frame_msg_id,
   output logic                           rsp_length_rejected,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gubp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gubp_pkg::BYTE_W-1:0]    csr_data
);
   import gubp_pkg::*;

   csr_type           csr_ff, csr_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_valid_ff, out_valid_in;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [BYTE_W-1:0]   data_ff;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                ldone_ff;
   logic [LPOS_W-1:0]   llen_ff;
   logic                fdone_ff, fok_ff, lrej_ff;
   logic [BYTE_W-1:0]   fclass_ff, fid_ff;

   logic          advance, step, in_frame;
   frame_res_type frame_res;
   line_res_type  line_res;

   // ---- configuration ----
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAYLOAD_LENGTH: csr_in.payload_length = csr_data;
            CSR_ACCEPT_CLASS:   csr_in.accept_class   = csr_data;
            CSR_ACCEPT_ID:      csr_in.accept_id      = csr_data;
            default:            csr_in                = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.payload_length <= RST_PAYLOAD_LENGTH;
         csr_ff.accept_class   <= RST_ACCEPT_CLASS;
         csr_ff.accept_id      <= RST_ACCEPT_ID;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // ---- pipeline control ----
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign in_byte_in   = (req_valid && !req_stall) ? req_rx_byte : in_byte_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // ---- parsers ----
   gubp_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .csr      (csr_ff),
      .in_frame (in_frame),
      .res      (frame_res)
   );

   gubp_line u_line (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .in_frame (in_frame),
      .rx_byte  (in_byte_ff),
      .res      (line_res)
   );

   always_comb begin
      if (frame_res.payload) begin
         kind_in   = KIND_PAYLOAD;
         offset_in = frame_res.offset;
      end else if (line_res.stored) begin
         kind_in   = KIND_LINE;
         offset_in = line_res.offset;
      end else begin
         kind_in   = KIND_NONE;
         offset_in = '0;
      end
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff   <= kind_in;
         data_ff   <= in_byte_ff;
         offset_ff <= offset_in;
         ldone_ff  <= line_res.line_done;
         llen_ff   <= line_res.line_length;
         fdone_ff  <= frame_res.frame_done;
         fok_ff    <= frame_res.frame_ok;
         lrej_ff   <= frame_res.length_rejected;
         fclass_ff <= frame_res.frame_class;
         fid_ff    <= frame_res.frame_msg_id;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_byte_kind       = kind_ff;
   assign rsp_data_byte       = data_ff;
   assign rsp_byte_offset     = offset_ff;
   assign rsp_line_done       = ldone_ff;
   assign rsp_line_length     = llen_ff;
   assign rsp_frame_done      = fdone_ff;
   assign rsp_frame_ok        = fok_ff;
   assign rsp_frame_class     = fclass_ff;
   assign rsp_frame_msg_id    = fid_ff;
   assign rsp_length_rejected = lrej_ff;

   // ---- assertions ----
   // line and frame events come from exclusive modes
   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_line_done && rsp_frame_done))
      else $error("line and frame completion on the same byte");

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_frame_done)
      else $error("frame_ok without frame_done");

   a_offset_unstored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_kind == KIND_NONE |-> rsp_byte_offset == '0)
      else $error("offset reported for an unstored byte");

   // a held input byte must not be overwritten while the output is blocked
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a byte under back-pressure");

endmodule

// ===== bench/tb_gnss_ubx_nmea_byte_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gnss_ubx_nmea_byte_parser_unit
// Self-checking bench for the GNSS UBX/NMEA byte parser.
// ----------------------------------------------------------------------------
// Bytes go in through the request channel and every accepted byte is run
// through a behavioural copy of the parser kept in this bench. Each response
// is compared, field by field, with the oldest outstanding prediction. A short
// directed table comes first: reset values, both extremes of the byte, sync
// handling, a length reject, sync restart inside a payload and an oversized
// length setting. Random traffic follows, mostly UBX frames and NMEA lines
// with random content, plus noise and broken frames, under several register
// settings. Both sides idle at random; the response side also holds off once
// for a long stretch so that the parser backs up into its input.
// ----------------------------------------------------------------------------
module tb_gnss_ubx_nmea_byte_parser_unit;

   import gubp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned HOLD_CYCLES = 40;

   typedef struct packed {
      byte_kind_type       kind;
      logic [BYTE_W-1:0]   data;
      logic [OFFSET_W-1:0] offset;
      logic                line_done;
      logic [LPOS_W-1:0]   line_length;
      logic                frame_done;
      logic                frame_ok;
      logic [BYTE_W-1:0]   frame_class;
      logic [BYTE_W-1:0]   frame_msg_id;
      logic                length_rejected;
   } parse_res_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              has_exp;
      parse_res_type     exp;
   } rx_item_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_op_type;

   typedef struct packed {
      row_op_type           op;
      logic [CSR_IDX_W-1:0] idx;
      logic [BYTE_W-1:0]    val;
      logic                 has_exp;
      parse_res_type        exp;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_byte_kind;
   logic [BYTE_W-1:0]     rsp_data_byte;
   logic [OFFSET_W-1:0]   rsp_byte_offset;
   logic                  rsp_line_done;
   logic [LPOS_W-1:0]     rsp_line_length;
   logic                  rsp_frame_done;
   logic                  rsp_frame_ok;
   logic [BYTE_W-1:0]     rsp_frame_class;
   logic [BYTE_W-1:0]     rsp_frame_msg_id;
   logic                  rsp_length_rejected;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [BYTE_W-1:0]     csr_data = '0;

   gnss_ubx_nmea_byte_parser_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_byte_kind       (rsp_byte_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_byte_offset     (rsp_byte_offset),
      .rsp_line_done       (rsp_line_done),
      .rsp_line_length     (rsp_line_length),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_frame_class     (rsp_frame_class),
      .rsp_frame_msg_id    (rsp_frame_msg_id),
      .rsp_length_rejected (rsp_length_rejected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser mirror: registers and state
   logic [BYTE_W-1:0] cfg_len, cfg_class, cfg_id;
   logic              fr_active, sync_seen;
   logic [FPOS_W-1:0] fr_pos;
   logic [BYTE_W-1:0] cls_q, id_q, len_lo_q, sum_a, sum_b, ck_a_q;
   logic [LPOS_W-1:0] line_pos;

   rx_item_type   rx_q [$];
   parse_res_type res_expected [$];
   dir_row_type   dir_tab [$];
   rx_item_type   cur_item;
   parse_res_type want, seen, pred;

   int  bytes_taken = 0;
   int  queued = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  fail_count = 0;
   int  n_checked = 0, n_lines = 0, n_frames = 0, n_good = 0, n_rejects = 0;
   int  n_payload = 0;
   bit  quiet = 1'b0;
   bit  hold_rsp = 1'b0;

   function automatic void clear_parser_model();
      cfg_len   = RST_PAYLOAD_LENGTH;
      cfg_class = RST_ACCEPT_CLASS;
      cfg_id    = RST_ACCEPT_ID;
      fr_active = 1'b0;
      fr_pos    = POS_IDLE;
      sync_seen = 1'b0;
      cls_q     = '0;
      id_q      = '0;
      len_lo_q  = '0;
      sum_a     = '0;
      sum_b     = '0;
      ck_a_q    = '0;
      line_pos  = '0;
   endfunction

   function automatic void fletcher_add(input logic [BYTE_W-1:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
   endfunction

   // one byte through the parser mirror; state advances as a side effect
   function automatic parse_res_type parse_byte(input logic [BYTE_W-1:0] b);
      parse_res_type     r;
      logic [FPOS_W-1:0] len9;
      logic [FPOS_W-1:0] off9;
      r      = '0;
      r.kind = KIND_NONE;
      r.data = b;
      len9   = {1'b0, cfg_len};
      if (fr_active) begin
         if (fr_pos == POS_CLASS) begin
            cls_q = b;
            fletcher_add(b);
            fr_pos = POS_ID;
         end else if (fr_pos == POS_ID) begin
            id_q = b;
            fletcher_add(b);
            fr_pos = POS_LEN_LO;
         end else if (fr_pos == POS_LEN_LO) begin
            len_lo_q = b;
            fletcher_add(b);
            fr_pos = POS_LEN_HI;
         end else if (fr_pos == POS_LEN_HI) begin
            fletcher_add(b);
            if (b != 0 || len_lo_q != cfg_len || cfg_len > MAX_PAYLOAD) begin
               fr_active = 1'b0;
               r.length_rejected = 1'b1;
            end
            fr_pos = POS_PAYLOAD;
         end else if (fr_pos >= POS_PAYLOAD && fr_pos < POS_PAYLOAD + len9) begin
            fletcher_add(b);
            off9 = fr_pos - POS_PAYLOAD;
            r.kind = KIND_PAYLOAD;
            r.offset = off9[OFFSET_W-1:0];
            fr_pos = fr_pos + 1'b1;
         end else if (fr_pos == POS_PAYLOAD + len9) begin
            ck_a_q = b;
            fr_pos = fr_pos + 1'b1;
         end else if (fr_pos == POS_PAYLOAD + len9 + 1) begin
            r.frame_done = 1'b1;
            r.frame_ok = (cls_q == cfg_class && id_q == cfg_id &&
                          ck_a_q == sum_a && b == sum_b);
            fr_pos = POS_IDLE;
            fr_active = 1'b0;
         end else begin
            fr_active = 1'b0;
            fr_pos = POS_IDLE;
         end
      end else begin
         if (b == CHAR_CR || b == CHAR_LF) begin
            if (line_pos != 0) begin
               r.line_done = 1'b1;
               r.line_length = line_pos;
               line_pos = '0;
            end
         end else begin
            if (b == CHAR_DOLLAR || line_pos >= LINE_MAX) line_pos = '0;
            r.kind = KIND_LINE;
            r.offset = line_pos[OFFSET_W-1:0];
            line_pos = line_pos + 1'b1;
         end
      end
      // a completed sync pair restarts the frame after the byte is handled
      if (b == SYNC_SECOND && sync_seen) begin
         fr_active = 1'b1;
         fr_pos = POS_CLASS;
         sum_a = '0;
         sum_b = '0;
      end
      sync_seen = (b == SYNC_FIRST);
      r.frame_class = cls_q;
      r.frame_msg_id = id_q;
      return r;
   endfunction

   function automatic string fmt_res(input parse_res_type r);
      return $sformatf("kind=%0d byte=%02h off=%0d ldone=%0d llen=%0d fdone=%0d fok=%0d %s",
                       r.kind, r.data, r.offset, r.line_done, r.line_length,
                       r.frame_done, r.frame_ok,
                       $sformatf("cls=%02h id=%02h lrej=%0d", r.frame_class,
                                 r.frame_msg_id, r.length_rejected));
   endfunction

   // ---- directed table -----------------------------------------------------
   function automatic void tab_byte(input logic [BYTE_W-1:0] b);
      dir_row_type row;
      row = '0;
      row.op = ROW_BYTE;
      row.val = b;
      dir_tab.push_back(row);
   endfunction

   function automatic void tab_chk(input logic [BYTE_W-1:0] b, input byte_kind_type kind,
                                   input logic ldone, input logic [LPOS_W-1:0] llen,
                                   input logic fdone, input logic fok,
                                   input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
                                   input logic lrej);
      dir_row_type row;
      row = '0;
      row.op = ROW_BYTE;
      row.val = b;
      row.has_exp = 1'b1;
      row.exp.kind = kind;
      row.exp.data = b;
      row.exp.line_done = ldone;
      row.exp.line_length = llen;
      row.exp.frame_done = fdone;
      row.exp.frame_ok = fok;
      row.exp.frame_class = cls;
      row.exp.frame_msg_id = id;
      row.exp.length_rejected = lrej;
      dir_tab.push_back(row);
   endfunction

   function automatic void tab_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [BYTE_W-1:0] v);
      dir_row_type row;
      row = '0;
      row.op = ROW_CSR;
      row.idx = idx;
      row.val = v;
      dir_tab.push_back(row);
   endfunction

   function automatic void build_table();
      // first character after reset, then both byte extremes
      tab_chk(8'h41, KIND_LINE, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
      tab_byte(8'h00);
      tab_byte(8'hFF);
      tab_chk(CHAR_CR, KIND_NONE, 1'b1, 8'd3, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
      // empty line closes silently
      tab_chk(CHAR_LF, KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
      // a byte between the sync bytes breaks the pair
      tab_byte(SYNC_FIRST);
      tab_byte(8'h00);
      tab_byte(SYNC_SECOND);
      // frame with nonzero length high byte
      tab_byte(SYNC_FIRST);
      tab_byte(SYNC_SECOND);
      tab_byte(8'h01);
      tab_byte(8'h07);
      tab_byte(RST_PAYLOAD_LENGTH);
      tab_chk(8'h01, KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 8'h01, 8'h07, 1'b1);
      tab_csr(CSR_PAYLOAD_LENGTH, 8'd2);
      // line offset carries on after the frame; sync restart inside payload
      tab_byte(SYNC_FIRST);
      tab_byte(SYNC_SECOND);
      tab_byte(8'h01);
      tab_byte(8'h07);
      tab_byte(8'h02);
      tab_byte(8'h00);
      tab_byte(SYNC_FIRST);
      tab_byte(SYNC_SECOND);
      tab_byte(8'h01);
      tab_byte(8'h07);
      tab_byte(8'h02);
      tab_byte(8'h00);
      tab_byte(8'hAA);
      tab_byte(8'h55);
      tab_byte(8'h09);
      tab_chk(8'hDA, KIND_NONE, 1'b0, 8'd0, 1'b1, 1'b1, 8'h01, 8'h07, 1'b0);
      // required length beyond the maximum payload
      tab_csr(CSR_PAYLOAD_LENGTH, 8'd200);
      tab_byte(SYNC_FIRST);
      tab_byte(SYNC_SECOND);
      tab_byte(8'h01);
      tab_byte(8'h07);
      tab_byte(8'd200);
      tab_chk(8'h00, KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 8'h01, 8'h07, 1'b1);
      tab_byte(CHAR_DOLLAR);
      tab_byte(CHAR_LF);
   endfunction

   // ---- random traffic -----------------------------------------------------
   function automatic void queue_byte(input logic [BYTE_W-1:0] b);
      rx_item_type it;
      it = '0;
      it.rx = b;
      rx_q.push_back(it);
      queued++;
   endfunction

   function automatic void queue_frame(input bit clean);
      logic [BYTE_W-1:0] cls, id, lo, hi, ck_a, ck_b, x;
      int                n, cut, i, pick;
      cls  = (clean || $urandom_range(0, 3) != 0) ? cfg_class
                                                  : BYTE_W'($urandom_range(0, 255));
      id   = (clean || $urandom_range(0, 3) != 0) ? cfg_id
                                                  : BYTE_W'($urandom_range(0, 255));
      lo   = cfg_len;
      hi   = 8'h00;
      pick = clean ? 9 : $urandom_range(0, 9);
      if (pick == 0) lo = BYTE_W'($urandom_range(0, 255));
      else if (pick == 1) hi = BYTE_W'($urandom_range(1, 255));
      n    = (cfg_len > MAX_PAYLOAD) ? 0 : cfg_len;
      cut  = (!clean && $urandom_range(0, 9) == 0) ? $urandom_range(0, 3 + n) : -1;
      ck_a = '0;
      ck_b = '0;
      queue_byte(SYNC_FIRST);
      queue_byte(SYNC_SECOND);
      for (i = 0; i < 4 + n; i++) begin
         if (i == cut) return;   // truncated frame
         case (i)
            0:       x = cls;
            1:       x = id;
            2:       x = lo;
            3:       x = hi;
            default: x = BYTE_W'($urandom_range(0, 255));
         endcase
         queue_byte(x);
         ck_a = ck_a + x;
         ck_b = ck_b + ck_a;
      end
      if (!clean && $urandom_range(0, 7) == 0) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
      if (!clean && $urandom_range(0, 7) == 0) ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
      queue_byte(ck_a);
      queue_byte(ck_b);
   endfunction

   function automatic void queue_line(input int n);
      int i;
      queue_byte(CHAR_DOLLAR);
      for (i = 0; i < n; i++) queue_byte(BYTE_W'($urandom_range(8'h20, 8'h7E)));
      case ($urandom_range(0, 2))
         0: begin
            queue_byte(CHAR_CR);
            queue_byte(CHAR_LF);
         end
         1: queue_byte(CHAR_LF);
         default: queue_byte(CHAR_CR);
      endcase
   endfunction

   function automatic void queue_noise(input int n);
      int i;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0:       queue_byte(SYNC_FIRST);
            1:       queue_byte(SYNC_SECOND);
            2:       queue_byte(CHAR_DOLLAR);
            3:       queue_byte(CHAR_CR);
            4:       queue_byte(CHAR_LF);
            default: queue_byte(BYTE_W'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   function automatic void queue_mix(input int budget);
      int pick;
      queued = 0;
      while (queued < budget) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) queue_frame(1'b0);
         else if (pick < 17) queue_line($urandom_range(0, 12));
         else queue_noise($urandom_range(1, 6));
      end
   endfunction

   // ---- register port and drain --------------------------------------------
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PAYLOAD_LENGTH: cfg_len = v;
         CSR_ACCEPT_CLASS:   cfg_class = v;
         CSR_ACCEPT_ID:      cfg_id = v;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (rx_q.size() != 0 || req_valid || res_expected.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // ---- request side -------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pred = parse_byte(cur_item.rx);
            res_expected.push_back(cur_item.has_exp ? cur_item.exp : pred);
            bytes_taken++;
         end
         // a stalled transfer keeps its byte and valid untouched
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_q.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (rx_q.size() != 0) begin
               cur_item = rx_q.pop_front();
               req_rx_byte <= cur_item.rx;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- response side ------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.kind = byte_kind_type'(rsp_byte_kind);
            seen.data = rsp_data_byte;
            seen.offset = rsp_byte_offset;
            seen.line_done = rsp_line_done;
            seen.line_length = rsp_line_length;
            seen.frame_done = rsp_frame_done;
            seen.frame_ok = rsp_frame_ok;
            seen.frame_class = rsp_frame_class;
            seen.frame_msg_id = rsp_frame_msg_id;
            seen.length_rejected = rsp_length_rejected;
            if (res_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result: %s", fmt_res(seen));
            end else begin
               want = res_expected.pop_front();
               n_checked++;
               if (want.line_done) n_lines++;
               if (want.frame_done) n_frames++;
               if (want.frame_ok) n_good++;
               if (want.length_rejected) n_rejects++;
               if (want.kind == KIND_PAYLOAD) n_payload++;
               if (want.kind !== seen.kind || want.data !== seen.data ||
                   want.offset !== seen.offset || want.line_done !== seen.line_done ||
                   want.line_length !== seen.line_length ||
                   want.frame_done !== seen.frame_done || want.frame_ok !== seen.frame_ok ||
                   want.frame_class !== seen.frame_class ||
                   want.frame_msg_id !== seen.frame_msg_id ||
                   want.length_rejected !== seen.length_rejected) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch on result %0d", n_checked);
                     $display("  exp %s", fmt_res(want));
                     $display("  got %s", fmt_res(seen));
                  end
               end
            end
         end
         if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
         rsp_stall <= hold_rsp || (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // long hold-off so the parser fills and back-pressures its input
   initial begin
      wait (bytes_taken >= 90);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2000000;
      $display("timeout: %0d results still outstanding", res_expected.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      rx_item_type it;
      clear_parser_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      build_table();
      foreach (dir_tab[i]) begin
         if (dir_tab[i].op == ROW_CSR) begin
            wait_idle();
            write_csr(dir_tab[i].idx, dir_tab[i].val);
         end else begin
            it.rx = dir_tab[i].val;
            it.has_exp = dir_tab[i].has_exp;
            it.exp = dir_tab[i].exp;
            rx_q.push_back(it);
         end
      end

      // empty payloads, all-zero match values
      wait_idle();
      write_csr(CSR_PAYLOAD_LENGTH, 8'd0);
      write_csr(CSR_ACCEPT_CLASS, 8'h00);
      write_csr(CSR_ACCEPT_ID, 8'h00);
      queue_mix(40);

      wait_idle();
      write_csr(CSR_PAYLOAD_LENGTH, 8'd4);
      write_csr(CSR_ACCEPT_CLASS, BYTE_W'($urandom_range(0, 255)));
      write_csr(CSR_ACCEPT_ID, BYTE_W'($urandom_range(0, 255)));
      queue_mix(50);

      // largest payload and a line that overruns its limit
      wait_idle();
      write_csr(CSR_PAYLOAD_LENGTH, MAX_PAYLOAD);
      write_csr(CSR_ACCEPT_CLASS, 8'hFF);
      write_csr(CSR_ACCEPT_ID, 8'hFF);
      queue_frame(1'b1);
      queue_line(130);

      // every frame rejected; unused index must leave the registers alone
      wait_idle();
      write_csr(CSR_PAYLOAD_LENGTH, 8'hFF);
      write_csr(CSR_UNUSED, BYTE_W'($urandom_range(0, 255)));
      queue_mix(20);

      wait_idle();
      quiet = 1'b1;
      write_csr(CSR_PAYLOAD_LENGTH, BYTE_W'($urandom_range(1, 8)));
      write_csr(CSR_ACCEPT_CLASS, BYTE_W'($urandom_range(0, 255)));
      write_csr(CSR_ACCEPT_ID, BYTE_W'($urandom_range(0, 255)));
      queue_mix(30);

      wait_idle();
      repeat (4) @(posedge clock);
      $display("summary: %0d bytes checked, %0d payload bytes, %0d lines closed",
               n_checked, n_payload, n_lines);
      $display("summary: %0d frames completed (%0d good), %0d length rejects",
               n_frames, n_good, n_rejects);
      if (fail_count == 0 && res_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/gubp_pkg.sv
hdl/gubp_frame.sv
hdl/gubp_line.sv
hdl/gnss_ubx_nmea_byte_parser_unit.sv
bench/tb_gnss_ubx_nmea_byte_parser_unit.sv
